// ===== hw/rtl/bvti_pkg.sv =====
package bvti_pkg;

    // Input and configuration widths.
    localparam int ADC_BITS = 12;
    localparam int CFG_W    = 20;
    localparam logic [CFG_W-1:0] CFG_RESET = 20'd580942;

    // Millivolts are the Q16 product shifted down by the fraction bits.
    localparam int MV_FRAC = 16;
    localparam int MV_W    = 16;
    localparam int PROD_W  = ADC_BITS + CFG_W;

    // Breakpoint tables. Breakpoints are evenly spaced inside each table.
    localparam int ADV_N = 6;
    localparam int DW_N  = 8;
    localparam int Y_W   = 9;
    localparam int ADV_SEG_W = $clog2(ADV_N);
    localparam int DW_SEG_W  = $clog2(DW_N);

    localparam int ADV_DX    = 500;
    localparam int DW_DX     = 2000;
    localparam int ADV_SCALE = 1;
    localparam int DW_SCALE  = 10;
    localparam int ADV_OFF_W = $clog2(ADV_DX + 1);
    localparam int DW_OFF_W  = $clog2(DW_DX + 1);

    localparam logic [MV_W-1:0] ADV_X [ADV_N] = '{
        16'd11000, 16'd11500, 16'd12000, 16'd12500, 16'd13000, 16'd13500
    };
    localparam logic [Y_W-1:0] ADV_Y [ADV_N] = '{
        9'd234, 9'd235, 9'd236, 9'd237, 9'd238, 9'd239
    };
    localparam logic [MV_W-1:0] DW_X [DW_N] = '{
        16'd6000, 16'd8000, 16'd10000, 16'd12000,
        16'd14000, 16'd16000, 16'd18000, 16'd20000
    };
    localparam logic [Y_W-1:0] DW_Y [DW_N] = '{
        9'd300, 9'd240, 9'd180, 9'd100, 9'd50, 9'd20, 9'd12, 9'd10
    };

    // Interpolation numerator and the constant divide by reciprocal.
    localparam int NUM_W = 21;
    localparam int SUM_W = NUM_W + 1;
    localparam int REC_W = 13;
    localparam int MUL_W = NUM_W + REC_W;
    localparam int ADV_Q_W = 9;
    localparam int DW_Q_W  = 8;

    localparam logic [NUM_W-1:0] ADV_DXN = NUM_W'(ADV_DX);
    localparam logic [NUM_W-1:0] DW_DXN  = NUM_W'(DW_DX);
    localparam logic [NUM_W-1:0] ADV_DIV = NUM_W'(ADV_DX * ADV_SCALE);
    localparam logic [NUM_W-1:0] DW_DIV  = NUM_W'(DW_DX * DW_SCALE);
    localparam logic [REC_W-1:0] ADV_REC = REC_W'((1 << NUM_W) / (ADV_DX * ADV_SCALE));
    localparam logic [REC_W-1:0] DW_REC  = REC_W'((1 << NUM_W) / (DW_DX * DW_SCALE));

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified sample: voltage plus segment and offset for each table.
    typedef struct packed {
        logic [MV_W-1:0]      mv;
        logic [ADV_SEG_W-1:0] adv_seg;
        logic [ADV_OFF_W-1:0] adv_off;
        logic [DW_SEG_W-1:0]  dw_seg;
        logic [DW_OFF_W-1:0]  dw_off;
    } t_cls;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_q_status;

endpackage

// ===== hw/rtl/bvti_in_if.sv =====
interface bvti_in_if
    import bvti_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink (input valid, input adc_code, output ready);
endinterface

// ===== hw/rtl/bvti_out_if.sv =====
interface bvti_out_if
    import bvti_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MV_W-1:0]    battery_mv;
    logic [ADV_Q_W-1:0] advance_pulses;
    logic [DW_Q_W-1:0]  coil_dwell;

    modport source (output valid, output battery_mv, output advance_pulses,
                    output coil_dwell, input ready);
    modport sink (input valid, input battery_mv, input advance_pulses,
                  input coil_dwell, output ready);
endinterface

// ===== hw/rtl/bvti_front.sv =====
module bvti_front
    import bvti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_mv_per_count,
    bvti_in_if.sink          i_adc,
    output logic             o_push_valid,
    output t_cls             o_push_data,
    input  logic             i_push_ready
);

    logic             r_f1_valid;
    logic [MV_W-1:0]  r_f1_mv;
    logic             r_f2_valid;
    t_cls             r_f2_cls;

    logic              f1_ready;
    logic              f2_ready;
    logic [PROD_W-1:0] prod;
    t_cls              n_cls;
    logic [ADV_SEG_W-1:0] adv_cnt;
    logic [DW_SEG_W-1:0]  dw_cnt;

    assign f2_ready    = !r_f2_valid || i_push_ready;
    assign f1_ready    = !r_f1_valid || f2_ready;
    assign i_adc.ready = f1_ready;

    // The product never exceeds the millivolt range, so the shift needs no saturation.
    assign prod = PROD_W'(i_adc.adc_code) * PROD_W'(i_mv_per_count);

    // Segment is the number of interior breakpoints below the voltage.
    always_comb begin
        adv_cnt = '0;
        dw_cnt  = '0;
        for (int k = 1; k < ADV_N - 1; k++) begin
            if (r_f1_mv > ADV_X[k]) begin
                adv_cnt = adv_cnt + ADV_SEG_W'(1);
            end
        end
        for (int k = 1; k < DW_N - 1; k++) begin
            if (r_f1_mv > DW_X[k]) begin
                dw_cnt = dw_cnt + DW_SEG_W'(1);
            end
        end

        n_cls.mv = r_f1_mv;
        // Below the table the first segment at offset zero yields the first entry;
        // above it the last segment at full offset yields the last entry.
        if (r_f1_mv <= ADV_X[0]) begin
            n_cls.adv_seg = '0;
            n_cls.adv_off = '0;
        end else if (r_f1_mv >= ADV_X[ADV_N-1]) begin
            n_cls.adv_seg = ADV_SEG_W'(ADV_N - 2);
            n_cls.adv_off = ADV_OFF_W'(ADV_DX);
        end else begin
            n_cls.adv_seg = adv_cnt;
            n_cls.adv_off = ADV_OFF_W'(r_f1_mv - ADV_X[adv_cnt]);
        end
        if (r_f1_mv <= DW_X[0]) begin
            n_cls.dw_seg = '0;
            n_cls.dw_off = '0;
        end else if (r_f1_mv >= DW_X[DW_N-1]) begin
            n_cls.dw_seg = DW_SEG_W'(DW_N - 2);
            n_cls.dw_off = DW_OFF_W'(DW_DX);
        end else begin
            n_cls.dw_seg = dw_cnt;
            n_cls.dw_off = DW_OFF_W'(r_f1_mv - DW_X[dw_cnt]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (f1_ready) begin
                r_f1_valid <= i_adc.valid;
            end
            if (f2_ready) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_ready && i_adc.valid) begin
            r_f1_mv <= prod[MV_FRAC +: MV_W];
        end
        if (f2_ready && r_f1_valid) begin
            r_f2_cls <= n_cls;
        end
    end

    assign o_push_valid = r_f2_valid;
    assign o_push_data  = r_f2_cls;

endmodule

// ===== hw/rtl/bvti_queue.sv =====
module bvti_queue
    import bvti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    input  t_cls      i_push_data,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_cls      o_pop_data,
    input  logic      i_pop_ready,
    output t_q_status o_status
);

    t_cls               r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_ptr;
    logic [Q_IDX_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic push;
    logic pop;
    logic [Q_CNT_W-1:0] n_count;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    assign o_push_ready = !o_status.full;
    assign o_pop_valid  = !o_status.empty;
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_IDX_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_IDX_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/bvti_back.sv =====
module bvti_back
    import bvti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    input  t_cls       i_pop_data,
    output logic       o_pop_ready,
    bvti_out_if.source o_res
);

    logic               r_b1_valid;
    logic [MV_W-1:0]    r_b1_mv;
    logic [NUM_W-1:0]   r_b1_adv_num;
    logic [NUM_W-1:0]   r_b1_dw_num;
    logic               r_b2_valid;
    logic [MV_W-1:0]    r_b2_mv;
    logic [NUM_W-1:0]   r_b2_adv_num;
    logic [NUM_W-1:0]   r_b2_dw_num;
    logic [ADV_Q_W-1:0] r_b2_adv_q;
    logic [DW_Q_W-1:0]  r_b2_dw_q;
    logic               r_out_valid;
    logic [MV_W-1:0]    r_out_mv;
    logic [ADV_Q_W-1:0] r_out_adv;
    logic [DW_Q_W-1:0]  r_out_dw;

    logic b1_ready;
    logic b2_ready;
    logic b3_ready;

    logic [ADV_SEG_W-1:0] adv_seg_nx;
    logic [DW_SEG_W-1:0]  dw_seg_nx;
    logic [NUM_W-1:0]     adv_base;
    logic [NUM_W-1:0]     dw_base;
    logic signed [Y_W:0]  adv_delta;
    logic signed [Y_W:0]  dw_delta;
    logic signed [ADV_OFF_W+Y_W+1:0] adv_prod;
    logic signed [DW_OFF_W+Y_W+1:0]  dw_prod;
    logic signed [SUM_W-1:0] adv_sum;
    logic signed [SUM_W-1:0] dw_sum;
    logic [NUM_W-1:0] adv_num;
    logic [NUM_W-1:0] dw_num;

    logic [MUL_W-1:0] adv_mul;
    logic [MUL_W-1:0] dw_mul;

    logic [NUM_W-1:0] adv_rem;
    logic [NUM_W-1:0] dw_rem;

    assign b3_ready    = !r_out_valid || o_res.ready;
    assign b2_ready    = !r_b2_valid || b3_ready;
    assign b1_ready    = !r_b1_valid || b2_ready;
    assign o_pop_ready = b1_ready;

    // Stage one: numerator y1*dx + offset*(y2-y1), clamped at zero.
    always_comb begin
        adv_seg_nx = i_pop_data.adv_seg + ADV_SEG_W'(1);
        dw_seg_nx  = i_pop_data.dw_seg + DW_SEG_W'(1);
        adv_base   = NUM_W'(ADV_Y[i_pop_data.adv_seg]) * ADV_DXN;
        dw_base    = NUM_W'(DW_Y[i_pop_data.dw_seg]) * DW_DXN;
        adv_delta  = $signed({1'b0, ADV_Y[adv_seg_nx]}) - $signed({1'b0, ADV_Y[i_pop_data.adv_seg]});
        dw_delta   = $signed({1'b0, DW_Y[dw_seg_nx]}) - $signed({1'b0, DW_Y[i_pop_data.dw_seg]});
        adv_prod   = $signed({1'b0, i_pop_data.adv_off}) * adv_delta;
        dw_prod    = $signed({1'b0, i_pop_data.dw_off}) * dw_delta;
        adv_sum    = $signed({1'b0, adv_base}) + SUM_W'(adv_prod);
        dw_sum     = $signed({1'b0, dw_base}) + SUM_W'(dw_prod);
        adv_num    = adv_sum[SUM_W-1] ? '0 : adv_sum[NUM_W-1:0];
        dw_num     = dw_sum[SUM_W-1] ? '0 : dw_sum[NUM_W-1:0];
    end

    // Stage two: quotient estimate, low by at most one.
    assign adv_mul = MUL_W'(r_b1_adv_num) * MUL_W'(ADV_REC);
    assign dw_mul  = MUL_W'(r_b1_dw_num) * MUL_W'(DW_REC);

    // Stage three: remainder check corrects the estimate.
    assign adv_rem = r_b2_adv_num - NUM_W'(r_b2_adv_q) * ADV_DIV;
    assign dw_rem  = r_b2_dw_num - NUM_W'(r_b2_dw_q) * DW_DIV;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_pop_valid;
            end
            if (b2_ready) begin
                r_b2_valid <= r_b1_valid;
            end
            if (b3_ready) begin
                r_out_valid <= r_b2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_ready && i_pop_valid) begin
            r_b1_mv      <= i_pop_data.mv;
            r_b1_adv_num <= adv_num;
            r_b1_dw_num  <= dw_num;
        end
        if (b2_ready && r_b1_valid) begin
            r_b2_mv      <= r_b1_mv;
            r_b2_adv_num <= r_b1_adv_num;
            r_b2_dw_num  <= r_b1_dw_num;
            r_b2_adv_q   <= adv_mul[NUM_W +: ADV_Q_W];
            r_b2_dw_q    <= dw_mul[NUM_W +: DW_Q_W];
        end
        if (b3_ready && r_b2_valid) begin
            r_out_mv  <= r_b2_mv;
            r_out_adv <= r_b2_adv_q + ADV_Q_W'(adv_rem >= ADV_DIV);
            r_out_dw  <= r_b2_dw_q + DW_Q_W'(dw_rem >= DW_DIV);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.battery_mv     = r_out_mv;
    assign o_res.advance_pulses = r_out_adv;
    assign o_res.coil_dwell     = r_out_dw;

endmodule

// ===== hw/rtl/battery_voltage_timing_interpolator.sv =====
// Channel    | Dir | Handshake     | Payload
// -----------+-----+---------------+----------------------------------------------
// i_adc      | in  | valid / ready | adc_code[11:0]
// o_res      | out | valid / ready | battery_mv[15:0], advance_pulses[8:0], coil_dwell[7:0]
// i_cfg_*    | in  | write enable  | i_cfg_wdata[19:0] = millivolts per count, Q16
//
// One transaction is accepted per cycle while the output is not stalled; a result
// is registered through two front stages (scale, classify), the queue and three back
// stages (numerator, reciprocal multiply, remainder correction).
// Reset is synchronous and active low; it empties the pipeline and the queue and loads
// the default scale factor.
// A stall on the output fills the back stages, then the four-entry queue, then the two
// front stages before the input side stops accepting.
module battery_voltage_timing_interpolator
    import bvti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bvti_in_if.sink          i_adc,
    bvti_out_if.source       o_res
);

    // Scale factor register. The user must write it only while the block is idle, so the
    // pipeline never sees it change under a sample in flight; the block does not enforce this.
    logic [CFG_W-1:0] r_mv_per_count;

    // Front to queue and queue to back handshakes.
    logic      push_valid;
    t_cls      push_data;
    logic      push_ready;
    logic      pop_valid;
    t_cls      pop_data;
    logic      pop_ready;
    t_q_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_per_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_mv_per_count <= i_cfg_wdata;
        end
    end

    // The front scales the code to millivolts and picks the segment and offset
    // in each breakpoint table.
    bvti_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mv_per_count (r_mv_per_count),
        .i_adc          (i_adc),
        .o_push_valid   (push_valid),
        .o_push_data    (push_data),
        .i_push_ready   (push_ready)
    );

    // The queue lets the front keep accepting while the output is briefly stalled.
    bvti_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready),
        .o_status     (q_status)
    );

    // The back interpolates and divides by the constant segment width times scale.
    bvti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");

    // Advance is always within the end values of its table.
    a_advance_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.advance_pulses >= ADV_Q_W'(234)) &&
                        (o_res.advance_pulses <= ADV_Q_W'(239)))
        else $error("advance outside table range");

    // Dwell is always within the end values of its table divided by its scale, in whole milliseconds.
    a_dwell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.coil_dwell >= DW_Q_W'(1)) && (o_res.coil_dwell <= DW_Q_W'(30)))
        else $error("dwell outside table range");

    // The queue level stays within its depth and agrees with its empty flag.
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.count <= Q_CNT_W'(Q_DEPTH)) &&
        (q_status.empty == (q_status.count == '0)))
        else $error("queue level inconsistent");
`endif

endmodule
